// File: rtl/core/single_wire_humidity_sensor_reader_top_defines.svh
// assertion macros for the single-wire humidity sensor reader
// used by single_wire_humidity_sensor_reader_top; expects clk and arst_n in scope
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWHR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SWHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/swhr_pkg.sv
// shared types, constants and frame helpers for the single-wire humidity sensor reader
// no dependencies; imported by single_wire_humidity_sensor_reader_top
package swhr_pkg;

	localparam int FRAME_BITS = 40;
	localparam int CNT_W      = 6;
	localparam int TIMER_W    = 16;
	localparam int IVAL_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [TIMER_W-1:0] RELEASE_RST   = 16'd1000;
	localparam logic [TIMER_W-1:0] START_LOW_RST = 16'd1100;
	localparam logic [TIMER_W-1:0] SETTLE_RST    = 16'd55;
	localparam logic [TIMER_W-1:0] TIMEOUT_RST   = 16'd1000;
	localparam logic [IVAL_W-1:0]  MIN_IVAL_RST  = 32'd2000000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVAL  = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RELEASE,
		PH_START,
		PH_SETTLE,
		PH_RESP_LOW,
		PH_RESP_HIGH,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} swhr_phase_t;

	typedef logic [FRAME_BITS-1:0] swhr_frame_t;

	// fifth byte must equal the low byte of the sum of the first four
	function automatic logic frame_checksum_ok(input swhr_frame_t f);
		logic [7:0] sum;
		sum = f[39:32] + f[31:24] + f[23:16] + f[15:8];
		return sum == f[7:0];
	endfunction

	// sign-magnitude temperature to two's complement
	function automatic logic signed [15:0] frame_temperature(input swhr_frame_t f);
		logic [15:0] mag;
		mag = {1'b0, f[22:16], f[15:8]};
		return f[23] ? signed'(16'(-mag)) : signed'(mag);
	endfunction

endpackage

// File: rtl/core/single_wire_humidity_sensor_reader_top.sv
// single-wire humidity/temperature sensor reader, one line sample per beat
// depends on swhr_pkg and single_wire_humidity_sensor_reader_top_defines.svh
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid in_ready pin_level read_request        | sink
//          | force_req                                       |
//  out     | out_valid out_ready drive_low busy_res done_res | source
//          | read_ok humidity_tenths temperature_tenths      |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | sink
//
// one beat in, one beat out; the sequencer state and the output
// register update together, so a new sample is taken every cycle unless the output stalls.
// each result beat is registered and appears in the cycle after its input beat.
// a stalled output holds the input off only while the output register is full.
// arst_n clears the sequencer, counters and output valid, and loads register defaults.
`include "single_wire_humidity_sensor_reader_top_defines.svh"

module single_wire_humidity_sensor_reader_top
	import swhr_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         pin_level,
	input  logic                         read_request,
	input  logic                         force_req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         drive_low,
	output logic                         busy_res,
	output logic                         done_res,
	output logic                         read_ok,
	output logic        [15:0]           humidity_tenths,
	output logic signed [15:0]           temperature_tenths,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic        [CFG_IDX_W-1:0]  cfg_index,
	input  logic        [CFG_DATA_W-1:0] cfg_data
);

	logic [TIMER_W-1:0] release_q, start_low_q, settle_q, timeout_q;
	logic [IVAL_W-1:0]  min_ival_q;

	swhr_phase_t        phase_q, phase_d;
	logic [TIMER_W-1:0] timer_q, timer_d, timer_inc;
	logic [TIMER_W-1:0] low_q, low_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	swhr_frame_t        frame_q, frame_d, frame_shift;
	logic [IVAL_W-1:0]  since_q, since_d;
	logic               last_ok_q, last_ok_d;

	logic               in_beat;
	logic               done, ok, accepted;
	logic               track_to, bit_val;

	logic               out_valid_q;
	logic               drive_low_q, busy_q, done_q, ok_q;
	logic        [15:0] hum_q;
	logic signed [15:0] temp_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q   <= RELEASE_RST;
			start_low_q <= START_LOW_RST;
			settle_q    <= SETTLE_RST;
			timeout_q   <= TIMEOUT_RST;
			min_ival_q  <= MIN_IVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RELEASE:   release_q   <= cfg_data[TIMER_W-1:0];
				CFG_START_LOW: start_low_q <= cfg_data[TIMER_W-1:0];
				CFG_SETTLE:    settle_q    <= cfg_data[TIMER_W-1:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data[TIMER_W-1:0];
				CFG_MIN_IVAL:  min_ival_q  <= cfg_data[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// shared step terms
	assign timer_inc   = (timer_q == '1) ? timer_q : timer_q + 1'b1;
	assign track_to    = timer_q >= timeout_q;
	assign bit_val     = timer_q > low_q;
	assign frame_shift = {frame_q[FRAME_BITS-2:0], bit_val};
	assign cnt_inc     = cnt_q + 1'b1;

	// next state of the read sequencer
	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		low_d     = low_q;
		cnt_d     = cnt_q;
		frame_d   = frame_q;
		last_ok_d = last_ok_q;
		done      = 1'b0;
		ok        = 1'b0;
		accepted  = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (read_request) begin
					if (!force_req && since_q < min_ival_q) begin
						done = 1'b1;
						ok   = last_ok_q;
					end else begin
						accepted = 1'b1;
						phase_d  = PH_RELEASE;
						timer_d  = '0;
						low_d    = '0;
						cnt_d    = '0;
						frame_d  = '0;
					end
				end
			end
			PH_RELEASE: begin
				if (timer_inc >= release_q) begin
					phase_d = PH_START;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_START: begin
				if (timer_inc >= start_low_q) begin
					phase_d = PH_SETTLE;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_SETTLE: begin
				if (timer_inc >= settle_q) begin
					phase_d = PH_RESP_LOW;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_RESP_LOW: begin
				if (!pin_level) begin
					if (track_to) done = 1'b1;
					else timer_d = timer_q + 1'b1;
				end else begin
					phase_d = PH_RESP_HIGH;
					timer_d = TIMER_W'(1);
				end
			end
			PH_RESP_HIGH: begin
				if (pin_level) begin
					if (track_to) done = 1'b1;
					else timer_d = timer_q + 1'b1;
				end else begin
					phase_d = PH_BIT_LOW;
					timer_d = TIMER_W'(1);
				end
			end
			PH_BIT_LOW: begin
				if (!pin_level) begin
					if (track_to) done = 1'b1;
					else timer_d = timer_q + 1'b1;
				end else begin
					low_d   = timer_q;
					phase_d = PH_BIT_HIGH;
					timer_d = TIMER_W'(1);
				end
			end
			PH_BIT_HIGH: begin
				if (pin_level) begin
					if (track_to) done = 1'b1;
					else timer_d = timer_q + 1'b1;
				end else begin
					// bit is 1 when high phase outlasts low phase
					frame_d = frame_shift;
					cnt_d   = cnt_inc;
					if (cnt_inc >= CNT_W'(FRAME_BITS)) begin
						done = 1'b1;
						ok   = frame_checksum_ok(frame_shift);
					end else begin
						phase_d = PH_BIT_LOW;
						timer_d = TIMER_W'(1);
					end
				end
			end
		endcase
		// completion of an accepted read
		if (done && phase_q != PH_IDLE) begin
			last_ok_d = ok;
			phase_d   = PH_IDLE;
			timer_d   = '0;
		end
	end

	// saturating interval counter
	always_comb begin
		if (accepted) since_d = '0;
		else if (since_q == '1) since_d = since_q;
		else since_d = since_q + 1'b1;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			low_q     <= '0;
			cnt_q     <= '0;
			frame_q   <= '0;
			since_q   <= '0;
			last_ok_q <= 1'b0;
		end else if (in_beat) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			low_q     <= low_d;
			cnt_q     <= cnt_d;
			frame_q   <= frame_d;
			since_q   <= since_d;
			last_ok_q <= last_ok_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			drive_low_q <= phase_d == PH_START;
			busy_q      <= phase_d != PH_IDLE;
			done_q      <= done;
			ok_q        <= done && ok;
			hum_q       <= (done && ok) ? frame_d[39:24] : 16'd0;
			temp_q      <= (done && ok) ? frame_temperature(frame_d) : 16'sd0;
		end
	end

	assign out_valid          = out_valid_q;
	assign drive_low          = drive_low_q;
	assign busy_res           = busy_q;
	assign done_res           = done_q;
	assign read_ok            = ok_q;
	assign humidity_tenths    = hum_q;
	assign temperature_tenths = temp_q;

	// checks
	`SWHR_ASSERT_NOW(a_drive_needs_busy, out_valid_q && drive_low_q, busy_q, "line driven while not busy")
	`SWHR_ASSERT_NOW(a_done_ends_read, out_valid_q && done_q, !busy_q, "completion left sequencer busy")
	`SWHR_ASSERT_NOW(a_idle_zero, out_valid_q && !done_q, !ok_q && hum_q == 16'd0 && temp_q == 16'sd0, "values without completion")
	`SWHR_ASSERT_NEXT(a_accept_clears_ival, in_beat && accepted, since_q == '0 && phase_q == PH_RELEASE, "accepted read did not start")

endmodule
